@@ src/msc_pkg.sv @@
// Shared types, constants and case tables for the marching squares contour unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package msc_pkg;

    // Default sizing
    localparam int MAX_CELLS_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int COORD_W   = 32;
    localparam int STEP_W    = 31;
    localparam int CELLS_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Input request: one grid sample
    typedef struct packed {
        logic signed [COORD_W-1:0] sample_value;
        logic                      sample_finite;
        logic                      first_sample;
    } sample_t;

    // Output request: one contour segment
    typedef struct packed {
        logic signed [COORD_W-1:0] seg_x0;
        logic signed [COORD_W-1:0] seg_y0;
        logic signed [COORD_W-1:0] seg_x1;
        logic signed [COORD_W-1:0] seg_y1;
        logic                      last_of_run;
    } seg_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS    = 3'd0,
        REG_X_ORIGIN = 3'd1,
        REG_Y_ORIGIN = 3'd2,
        REG_X_STEP   = 3'd3,
        REG_Y_STEP   = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BASE,
        ST_BASE2,
        ST_EDGE,
        ST_DIV,
        ST_MUL,
        ST_ROUND,
        ST_EMIT0,
        ST_EMIT1
    } msc_state_t;

    // Number of segments for a corner mask
    function automatic logic [1:0] seg_count(input logic [3:0] mask);
        logic [1:0] n;
        begin
            unique case (mask)
                4'd0, 4'd15: n = 2'd0;
                4'd5, 4'd10: n = 2'd2;
                default:     n = 2'd1;
            endcase
            return n;
        end
    endfunction

    // Edge k (0..3) of the segment list for a corner mask
    function automatic logic [1:0] seg_edge(input logic [3:0] mask, input logic [1:0] k);
        logic [7:0] row;
        begin
            unique case (mask)
                4'd1:    row = {2'd0, 2'd0, 2'd0, 2'd3};
                4'd2:    row = {2'd0, 2'd0, 2'd1, 2'd0};
                4'd3:    row = {2'd0, 2'd0, 2'd1, 2'd3};
                4'd4:    row = {2'd0, 2'd0, 2'd2, 2'd1};
                4'd5:    row = {2'd1, 2'd0, 2'd2, 2'd3};
                4'd6:    row = {2'd0, 2'd0, 2'd2, 2'd0};
                4'd7:    row = {2'd0, 2'd0, 2'd2, 2'd3};
                4'd8:    row = {2'd0, 2'd0, 2'd2, 2'd3};
                4'd9:    row = {2'd0, 2'd0, 2'd2, 2'd0};
                4'd10:   row = {2'd3, 2'd2, 2'd1, 2'd0};
                4'd11:   row = {2'd0, 2'd0, 2'd2, 2'd1};
                4'd12:   row = {2'd0, 2'd0, 2'd1, 2'd3};
                4'd13:   row = {2'd0, 2'd0, 2'd1, 2'd0};
                4'd14:   row = {2'd0, 2'd0, 2'd0, 2'd3};
                default: row = 8'd0;
            endcase
            return row[2*k +: 2];
        end
    endfunction

endpackage

@@ src/marching_squares_contour_unit.sv @@
// Marching squares contour unit: line buffer, cell sequencer, edge divider, output register.
// Depends on msc_pkg.
`timescale 1ns / 1ps

// Samples enter in raster order (bottom row first) and one sample is processed at a time.
// A sample that does not close a cell, or whose cell is uniform or has a non-finite corner,
// passes through the read state back to idle. A sample that yields segments goes through
// the read and two base setup states, then for each of its 2 or 4 crossing edges through the
// edge, multiply and round states (the radix-2 divider state runs between edge and multiply
// when needed), then two emit states, each held while a kept segment waits on a stalled
// output. The shared divider yields one bit per cycle. The previous row sits in a one-port
// synchronous buffer of MAX_CELLS+1 entries, read and written on acceptance.
module marching_squares_contour_unit #(
    parameter int MAX_CELLS = msc_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [msc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  msc_pkg::sample_t              sample,
    output logic                          seg_valid,
    input  logic                          seg_stall,
    output msc_pkg::seg_t                 seg
);
    import msc_pkg::*;

    localparam int DEPTH  = MAX_CELLS + 1;
    localparam int IDX_W  = $clog2(MAX_CELLS + 1);
    localparam int CMP_W  = CELLS_W + IDX_W;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int T_W    = FRAC_BITS + 1;
    localparam int PROD_W = IDX_W + STEP_W;
    localparam int CW     = PROD_W + 3;
    localparam int PW     = CW + 1;
    localparam int MAG_W  = STEP_W + T_W;
    localparam int OFF_W  = MAG_W + 1 - FRAC_BITS;
    localparam int D_W    = COORD_W + 1;

    // Saturate a wide coordinate to 32 bits
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [COORD_W-1:0] r;
        begin
            if (v > PW'(signed'(32'sh7FFFFFFF)))
                r = 32'sh7FFFFFFF;
            else if (v < PW'(signed'(32'sh80000000)))
                r = 32'sh80000000;
            else
                r = v[COORD_W-1:0];
            return r;
        end
    endfunction

    // Configuration registers
    logic [CELLS_W-1:0]        cells_reg;
    logic signed [COORD_W-1:0] x_origin_reg, y_origin_reg;
    logic [STEP_W-1:0]         x_step_reg, y_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg    <= CELLS_W'(1);
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            x_step_reg   <= STEP_W'(65536);
            y_step_reg   <= STEP_W'(65536);
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CELLS:    cells_reg    <= cfg_data[CELLS_W-1:0];
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_X_STEP:   x_step_reg   <= cfg_data[STEP_W-1:0];
                REG_Y_STEP:   y_step_reg   <= cfg_data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // State
    msc_state_t state_reg, state_next;
    logic [IDX_W-1:0] col_count_reg, row_count_reg;
    logic [IDX_W-1:0] col_reg, row_reg;
    logic [32:0]      cur_reg, left_reg, left_up_reg, upper_rd_reg;
    logic signed [COORD_W-1:0] v0_reg, v1_reg, v2_reg, v3_reg;
    logic [3:0]       mask_reg;
    logic             two_reg;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [CW-1:0] minx_reg, miny_reg, maxx_reg, maxy_reg;
    logic [1:0]       k_reg, edge_reg;
    logic [T_W-1:0]   t_reg;
    logic [D_W-1:0]   rem_reg, div_d_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [MAG_W-1:0] mag_reg;
    logic signed [COORD_W-1:0] pt_x_reg [4];
    logic signed [COORD_W-1:0] pt_y_reg [4];
    logic             seg_valid_reg;
    seg_t             seg_reg;

    // Handshakes
    logic acc;
    assign sample_stall = (state_reg != ST_IDLE);
    assign acc          = sample_valid && !sample_stall;
    assign seg_valid    = seg_valid_reg;
    assign seg          = seg_reg;

    // Effective cell count
    logic [CMP_W-1:0] cells_wide;
    logic [IDX_W-1:0] cells_eff;
    always_comb
    begin
        cells_wide = CMP_W'(cells_reg);
        if (cells_wide == '0)
            cells_wide = CMP_W'(1);
        else if (cells_wide > CMP_W'(MAX_CELLS))
            cells_wide = CMP_W'(MAX_CELLS);
        cells_eff = cells_wide[IDX_W-1:0];
    end

    // Position of the incoming sample
    logic [IDX_W-1:0] col_raw, col_sel, row_sel;
    assign col_raw = sample.first_sample ? '0 : col_count_reg;
    assign col_sel = (col_raw > IDX_W'(MAX_CELLS)) ? '0 : col_raw;
    assign row_sel = sample.first_sample ? '0 : row_count_reg;

    // Line buffer: read old entry and write new sample on acceptance
    logic [32:0] row_mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            upper_rd_reg     <= row_mem[col_sel];
            row_mem[col_sel] <= {sample.sample_finite, sample.sample_value};
        end
    end

    // Cell decode from the four corners
    logic [3:0] mask_c;
    logic       allf_c, cell_ok;
    always_comb
    begin
        mask_c  = {left_reg[31:0] > 0 && !left_reg[31],
                   cur_reg[31:0] != 0 && !cur_reg[31],
                   upper_rd_reg[31:0] != 0 && !upper_rd_reg[31],
                   left_up_reg[31:0] != 0 && !left_up_reg[31]};
        allf_c  = left_up_reg[32] && upper_rd_reg[32] && cur_reg[32] && left_reg[32];
        cell_ok = (col_reg != '0) && (row_reg != '0) && allf_c && (seg_count(mask_c) != 2'd0);
    end

    // Edge setup: corner values and divide decision
    logic [1:0]                edge_c;
    logic signed [COORD_W-1:0] va, vb;
    logic signed [D_W-1:0]     d_c;
    logic [D_W-1:0]            abs_va, abs_d;
    always_comb
    begin
        edge_c = seg_edge(mask_reg, k_reg);
        unique case (edge_c)
            2'd0:    begin va = v0_reg; vb = v1_reg; end
            2'd1:    begin va = v1_reg; vb = v2_reg; end
            2'd2:    begin va = v2_reg; vb = v3_reg; end
            default: begin va = v3_reg; vb = v0_reg; end
        endcase
        d_c    = D_W'(va) - D_W'(vb);
        abs_va = va[COORD_W-1] ? D_W'(-D_W'(va)) : D_W'(va);
        abs_d  = d_c[D_W-1] ? D_W'(-d_c) : D_W'(d_c);
    end

    // Divider step
    logic [D_W:0] r2;
    logic         q_bit;
    assign r2    = {rem_reg, 1'b0};
    assign q_bit = (r2 >= (D_W+1)'(div_d_reg));

    // Coordinate rounding
    logic [MAG_W:0]       rounded;
    logic [OFF_W-1:0]     off;
    logic signed [PW-1:0] off_s, mv_c, fx_c;
    always_comb
    begin
        rounded = (MAG_W+1)'(mag_reg) + (MAG_W+1)'(1 << (FRAC_BITS - 1));
        off     = rounded[MAG_W:FRAC_BITS];
        off_s   = PW'(off);
        unique case (edge_reg)
            2'd0:    begin mv_c = PW'(minx_reg) + off_s; fx_c = PW'(miny_reg); end
            2'd1:    begin mv_c = PW'(miny_reg) + off_s; fx_c = PW'(maxx_reg); end
            2'd2:    begin mv_c = PW'(maxx_reg) - off_s; fx_c = PW'(maxy_reg); end
            default: begin mv_c = PW'(maxy_reg) - off_s; fx_c = PW'(minx_reg); end
        endcase
    end

    // Segment keep decisions
    logic keep0, keep1, out_free, last_edge;
    assign keep0     = !(pt_x_reg[0] == pt_x_reg[1] && pt_y_reg[0] == pt_y_reg[1]);
    assign keep1     = two_reg && !(pt_x_reg[2] == pt_x_reg[3] && pt_y_reg[2] == pt_y_reg[3]);
    assign out_free  = !seg_valid_reg || !seg_stall;
    assign last_edge = (k_reg == {two_reg, 1'b1});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (acc) state_next = ST_READ;
            ST_READ:  state_next = cell_ok ? ST_BASE : ST_IDLE;
            ST_BASE:  state_next = ST_BASE2;
            ST_BASE2: state_next = ST_EDGE;
            ST_EDGE:
            begin
                if (d_c != '0 && va != '0 && (va[COORD_W-1] == d_c[D_W-1])
                    && abs_va < abs_d)
                    state_next = ST_DIV;
                else
                    state_next = ST_MUL;
            end
            ST_DIV:   if (div_cnt_reg == CNT_W'(FRAC_BITS - 1)) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ROUND;
            ST_ROUND: state_next = last_edge ? ST_EMIT0 : ST_EDGE;
            ST_EMIT0: if (!keep0 || out_free) state_next = ST_EMIT1;
            ST_EMIT1: if (!keep1 || out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output loads
    logic  seg_load;
    seg_t  seg_c;
    always_comb
    begin
        seg_load = 1'b0;
        seg_c    = seg_reg;
        unique case (state_reg)
            ST_EMIT0:
            begin
                seg_load = keep0 && out_free;
                seg_c    = '{pt_x_reg[0], pt_y_reg[0], pt_x_reg[1], pt_y_reg[1], !keep1};
            end
            ST_EMIT1:
            begin
                seg_load = keep1 && out_free;
                seg_c    = '{pt_x_reg[2], pt_y_reg[2], pt_x_reg[3], pt_y_reg[3], 1'b1};
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
            left_up_reg   <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                if (col_sel >= cells_eff)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= (row_sel >= cells_eff) ? '0 : row_sel + 1'b1;
                end
                else
                begin
                    col_count_reg <= col_sel + 1'b1;
                    row_count_reg <= row_sel;
                end
            end
            if (state_reg == ST_READ)
            begin
                left_up_reg <= upper_rd_reg;
                left_reg    <= cur_reg;
            end
            if (seg_load)
                seg_valid_reg <= 1'b1;
            else if (!seg_stall)
                seg_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (seg_load)
            seg_reg <= seg_c;
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= {sample.sample_finite, sample.sample_value};
                col_reg <= col_sel;
                row_reg <= row_sel;
            end
            ST_READ:
            begin
                v0_reg     <= left_up_reg[31:0];
                v1_reg     <= upper_rd_reg[31:0];
                v2_reg     <= cur_reg[31:0];
                v3_reg     <= left_reg[31:0];
                mask_reg   <= mask_c;
                two_reg    <= (seg_count(mask_c) == 2'd2);
                prod_x_reg <= PROD_W'(col_reg - 1'b1) * PROD_W'(x_step_reg);
                prod_y_reg <= PROD_W'(row_reg - 1'b1) * PROD_W'(y_step_reg);
                k_reg      <= '0;
            end
            ST_BASE:
            begin
                minx_reg <= CW'(x_origin_reg) + CW'(prod_x_reg);
                miny_reg <= CW'(y_origin_reg) + CW'(prod_y_reg);
            end
            ST_BASE2:
            begin
                maxx_reg <= minx_reg + CW'(x_step_reg);
                maxy_reg <= miny_reg + CW'(y_step_reg);
            end
            ST_EDGE:
            begin
                edge_reg    <= edge_c;
                rem_reg     <= abs_va;
                div_d_reg   <= abs_d;
                div_cnt_reg <= '0;
                if (d_c == '0)
                    t_reg <= T_W'(1 << (FRAC_BITS - 1));
                else if (va == '0 || (va[COORD_W-1] != d_c[D_W-1]))
                    t_reg <= '0;
                else if (abs_va >= abs_d)
                    t_reg <= T_W'(1 << FRAC_BITS);
                else
                    t_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg     <= q_bit ? D_W'(r2 - (D_W+1)'(div_d_reg)) : D_W'(r2);
                t_reg       <= {t_reg[T_W-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ST_MUL:
                mag_reg <= MAG_W'(edge_reg[0] ? y_step_reg : x_step_reg) * MAG_W'(t_reg);
            ST_ROUND:
            begin
                if (edge_reg[0])
                begin
                    pt_x_reg[k_reg] <= sat32(fx_c);
                    pt_y_reg[k_reg] <= sat32(mv_c);
                end
                else
                begin
                    pt_x_reg[k_reg] <= sat32(mv_c);
                    pt_y_reg[k_reg] <= sat32(fx_c);
                end
                k_reg <= k_reg + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // An accepted sample always goes to the line buffer read stage
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> state_reg == ST_READ)
        else $error("accepted sample did not enter read stage");

    // Divider never runs past the fraction width
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_cnt_reg < CNT_W'(FRAC_BITS))
        else $error("divider count overrun");

    // A segment is loaded only from an emit state with a free output
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        seg_load |-> out_free && (state_reg == ST_EMIT0 || state_reg == ST_EMIT1))
        else $error("segment loaded while output busy");
`endif

endmodule
